/* design/bcf_pkg.sv */
// ---------------------------------------------------------------------------
// bcf_pkg: shared types and constants of the biquad cascade filter
// Payload structs, section link and coefficient write records, sizing
// constants and the saturation helpers used by the section cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcf_pkg;

  // Sizing
  localparam int MAX_SECTIONS = 8;
  localparam int COEF_BITS    = 32;
  localparam int COEFS_PER_SEC = 5;
  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Coefficient precision: clear the bits below COEF_BITS
  localparam logic [31:0] COEF_MASK = ~((32'd1 << (32 - COEF_BITS)) - 32'd1);

  typedef logic [SEC_W-1:0] sec_idx_t;
  typedef logic [2:0]       coef_sel_t;
  typedef logic signed [31:0] coef_t;
  typedef logic signed [23:0] smp_t;
  typedef logic signed [47:0] delay_t;

  // Coefficient slots within one section
  localparam coef_sel_t C_B0 = 3'd0;
  localparam coef_sel_t C_B1 = 3'd1;
  localparam coef_sel_t C_B2 = 3'd2;
  localparam coef_sel_t C_A1 = 3'd3;
  localparam coef_sel_t C_A2 = 3'd4;

  // Function codes of an input request
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic  func;
    smp_t  sample_in;
    logic [5:0] coef_slot;
    coef_t coef_value;
  } in_item_t;

  typedef struct packed {
    smp_t sample_out;
    logic clipped;
  } out_item_t;

  // Sample handed from one section to the next
  typedef struct packed {
    logic vld;
    smp_t y;
    logic clip;
  } sec_link_t;

  // Coefficient write into one section
  typedef struct packed {
    logic      we;
    coef_sel_t sel;
    coef_t     value;
  } coef_wr_t;

  // Saturate a 52-bit signed value to the 48-bit delay range
  function automatic delay_t sat_delay(input logic signed [51:0] v);
    delay_t r;
    if (v[51:47] != {5{v[47]}}) begin
      r = v[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Saturate a 28-bit signed value to a 24-bit sample
  function automatic smp_t sat_sample(input logic signed [27:0] v);
    smp_t r;
    if (v[27:23] != {5{v[23]}}) begin
      r = v[27] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Flag a 28-bit signed value outside the 24-bit sample range
  function automatic logic sample_ovf(input logic signed [27:0] v);
    return (v[27:23] != {5{v[23]}});
  endfunction

endpackage

`default_nettype wire

/* design/bcf_section.sv */
// ---------------------------------------------------------------------------
// bcf_section: one second-order section cell of the cascade
// Holds its five coefficients and two delay registers, runs the transposed
// direct form II update on one shared 32x24 multiplier and hands its output
// sample to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcf_section (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en_i,
  input  wire bcf_pkg::sec_link_t link_i,
  input  wire bcf_pkg::coef_wr_t  coef_wr_i,
  output bcf_pkg::sec_link_t      link_o,
  output logic                    done_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MB0   = 7'b0000010,
    ST_MB1_Y = 7'b0000100,
    ST_MA1   = 7'b0001000,
    ST_MB2   = 7'b0010000,
    ST_MA2   = 7'b0100000,
    ST_UPD   = 7'b1000000
  } sec_state_t;

  sec_state_t state_r, state_nxt;

  bcf_pkg::coef_t  coef_r [bcf_pkg::COEFS_PER_SEC];
  bcf_pkg::delay_t d1_r, d1_nxt;
  bcf_pkg::delay_t d2_r, d2_nxt;
  bcf_pkg::smp_t   x_r, x_nxt;
  bcf_pkg::smp_t   y_r, y_nxt;
  logic            clip_r, clip_nxt;
  logic signed [55:0] prod_r, prod_nxt;
  logic signed [55:0] hold_r, hold_nxt;
  logic signed [56:0] f_r, f_nxt;

  bcf_pkg::coef_sel_t mul_sel;
  bcf_pkg::coef_t     mul_a;
  bcf_pkg::smp_t      mul_b;
  logic signed [50:0] acc_w;
  logic signed [51:0] rnd_w;
  logic signed [27:0] yfull_w;
  logic signed [56:0] diff_w;
  logic signed [51:0] d1_sum_w;
  logic signed [51:0] d2_sum_w;
  logic               start;

  assign start = link_i.vld & en_i & (state_r == ST_IDLE);

  // Pick multiplier operands for the current step
  always_comb begin
    mul_sel = bcf_pkg::C_B0;
    mul_b   = x_r;
    case (state_r)
      ST_MB0:   begin mul_sel = bcf_pkg::C_B0; mul_b = x_r; end
      ST_MB1_Y: begin mul_sel = bcf_pkg::C_B1; mul_b = x_r; end
      ST_MA1:   begin mul_sel = bcf_pkg::C_A1; mul_b = y_r; end
      ST_MB2:   begin mul_sel = bcf_pkg::C_B2; mul_b = x_r; end
      ST_MA2:   begin mul_sel = bcf_pkg::C_A2; mul_b = y_r; end
      default:  begin mul_sel = bcf_pkg::C_B0; mul_b = x_r; end
    endcase
  end

  assign mul_a = coef_r[mul_sel];

  // Output sample: add first delay, round half up, saturate
  assign acc_w   = 51'(prod_r >>> 6) + 51'(d1_r);
  assign rnd_w   = 52'(acc_w) + 52'sh800000;
  assign yfull_w = 28'(rnd_w >>> 24);

  // Feedback terms
  assign diff_w   = 57'(hold_r) - 57'(prod_r);
  assign d1_sum_w = 52'(f_r >>> 6) + 52'(d2_r);
  assign d2_sum_w = 52'(diff_w >>> 6);

  // Sequence one sample through the five products
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    clip_nxt  = clip_r;
    prod_nxt  = prod_r;
    hold_nxt  = hold_r;
    f_nxt     = f_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = link_i.y;
          clip_nxt  = link_i.clip;
          state_nxt = ST_MB0;
        end
      end
      ST_MB0: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MB1_Y;
      end
      ST_MB1_Y: begin
        y_nxt     = bcf_pkg::sat_sample(yfull_w);
        clip_nxt  = clip_r | bcf_pkg::sample_ovf(yfull_w);
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MA1;
      end
      ST_MA1: begin
        hold_nxt  = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MB2;
      end
      ST_MB2: begin
        f_nxt     = diff_w;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MA2;
      end
      ST_MA2: begin
        hold_nxt  = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        d1_nxt    = bcf_pkg::sat_delay(d1_sum_w);
        d2_nxt    = bcf_pkg::sat_delay(d2_sum_w);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and delay state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d1_r    <= '0;
      d2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    clip_r <= clip_nxt;
    prod_r <= prod_nxt;
    hold_r <= hold_nxt;
    f_r    <= f_nxt;
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (coef_wr_i.we) begin
      case (coef_wr_i.sel)
        bcf_pkg::C_B0: coef_r[0] <= coef_wr_i.value;
        bcf_pkg::C_B1: coef_r[1] <= coef_wr_i.value;
        bcf_pkg::C_B2: coef_r[2] <= coef_wr_i.value;
        bcf_pkg::C_A1: coef_r[3] <= coef_wr_i.value;
        bcf_pkg::C_A2: coef_r[4] <= coef_wr_i.value;
        default: ;
      endcase
    end
  end

  // Hand the sample on once y is settled
  assign link_o.vld  = (state_r == ST_MA1);
  assign link_o.y    = y_r;
  assign link_o.clip = clip_r;
  assign done_o      = (state_r == ST_UPD);

endmodule

`default_nettype wire

/* design/biquad_cascade_filter_core.sv */
// ---------------------------------------------------------------------------
// biquad_cascade_filter_core: cascade of biquad sections for 24-bit audio
// Top level: request handshake, section count register, coefficient routing,
// the row of section cells and a two-entry result buffer.
// ---------------------------------------------------------------------------
// A filter request with n active sections (1 to 8) holds off new requests
// until the last active cell has updated its delays; its result enters the
// result buffer when that cell passes on its output sample. Each section
// cell computes its five products on one shared 32x24 multiplier, passes its
// output sample to the next cell once y is settled and then finishes its own
// delay update while the next cell runs. A coefficient write gives no result.
// Write cfg_wdata only while no filter request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_filter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bcf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bcf_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata
);

  logic [3:0] active_r;
  logic       busy_r, busy_nxt;
  logic       head_v_r, head_v_nxt;
  logic       skid_v_r, skid_v_nxt;
  bcf_pkg::out_item_t head_r, head_nxt;
  bcf_pkg::out_item_t skid_r, skid_nxt;

  bcf_pkg::sec_idx_t  last_idx;
  bcf_pkg::sec_link_t link_in  [bcf_pkg::MAX_SECTIONS];
  bcf_pkg::sec_link_t link_out [bcf_pkg::MAX_SECTIONS];
  bcf_pkg::coef_wr_t  coef_wr  [bcf_pkg::MAX_SECTIONS];
  logic [bcf_pkg::MAX_SECTIONS-1:0] sec_en;
  logic [bcf_pkg::MAX_SECTIONS-1:0] sec_done;

  logic               accept;
  logic               smp_acc;
  logic               coef_acc;
  logic               push;
  logic               pop;
  bcf_pkg::out_item_t res;
  bcf_pkg::sec_link_t last_link;

  // Take a request when idle and the result buffer has room
  assign in_stall = busy_r | skid_v_r;
  assign accept   = in_valid & ~in_stall;
  assign smp_acc  = accept & (in_data.func == bcf_pkg::FUNC_FILTER);
  assign coef_acc = accept & (in_data.func == bcf_pkg::FUNC_COEF);

  // Section count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 4'd1;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // Clamp the section count to the cells present; a count of zero runs one section
  always_comb begin
    if (active_r == 4'd0) begin
      last_idx = '0;
    end else if (32'(active_r) > bcf_pkg::MAX_SECTIONS) begin
      last_idx = bcf_pkg::sec_idx_t'(bcf_pkg::MAX_SECTIONS - 1);
    end else begin
      last_idx = bcf_pkg::sec_idx_t'(active_r - 4'd1);
    end
  end

  // Feed the first cell straight from the input request
  assign link_in[0].vld  = smp_acc;
  assign link_in[0].y    = in_data.sample_in;
  assign link_in[0].clip = 1'b0;

  // Row of section cells
  for (genvar k = 0; k < bcf_pkg::MAX_SECTIONS; k++) begin : g_sec
    if (k > 0) begin : g_link
      assign link_in[k] = link_out[k-1];
    end

    assign sec_en[k] = (32'(last_idx) >= 32'(k));

    // Route coefficient writes that fall in this section's slots
    assign coef_wr[k].we = coef_acc
                         & (32'(in_data.coef_slot) >= 32'(bcf_pkg::COEFS_PER_SEC * k))
                         & (32'(in_data.coef_slot) <  32'(bcf_pkg::COEFS_PER_SEC * (k + 1)));
    assign coef_wr[k].sel   = bcf_pkg::coef_sel_t'(32'(in_data.coef_slot)
                                                   - 32'(bcf_pkg::COEFS_PER_SEC * k));
    assign coef_wr[k].value = in_data.coef_value & bcf_pkg::COEF_MASK;

    bcf_section u_sec (
      .clk       (clk),
      .rst_n     (rst_n),
      .en_i      (sec_en[k]),
      .link_i    (link_in[k]),
      .coef_wr_i (coef_wr[k]),
      .link_o    (link_out[k]),
      .done_o    (sec_done[k])
    );
  end

  // Result leaves the last active cell
  assign last_link      = link_out[last_idx];
  assign push           = busy_r & last_link.vld;
  assign res.sample_out = last_link.y;
  assign res.clipped    = last_link.clip;

  // Hold busy until the last active cell has updated its delays
  always_comb begin
    busy_nxt = busy_r;
    if (smp_acc) begin
      busy_nxt = 1'b1;
    end else if (sec_done[last_idx]) begin
      busy_nxt = 1'b0;
    end
  end

  // Two-entry result buffer: head drives the port, skid catches overflow
  assign pop = head_v_r & ~out_stall;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        head_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = res;
      end else if (push) begin
        head_nxt   = res;
        head_v_nxt = 1'b1;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = res;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

`default_nettype wire
